>>> src/kced_pkg.sv
// Shared types, codes and constants of the key click event detector.
`default_nettype none

package kced_pkg;

   localparam int KEYS      = 3;
   localparam int LEVEL_W   = 3;
   localparam int FLAG_W    = 7;
   localparam int TIME_W    = 16;
   localparam int PERIOD_W  = 8;
   localparam int CODE_W    = 4;
   localparam int CMD_W     = 2;
   localparam int KIND_W    = 3;
   localparam int INDEX_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int ORDER_N   = 3;

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;

   localparam logic [KIND_W-1:0] EV_HOLD   = 3'd0;
   localparam logic [KIND_W-1:0] EV_DOWN   = 3'd1;
   localparam logic [KIND_W-1:0] EV_UP     = 3'd2;
   localparam logic [KIND_W-1:0] EV_SINGLE = 3'd3;
   localparam logic [KIND_W-1:0] EV_DOUBLE = 3'd4;
   localparam logic [KIND_W-1:0] EV_LONG   = 3'd5;
   localparam logic [KIND_W-1:0] EV_REPEAT = 3'd6;

   localparam logic [KIND_W-1:0] STATUS_ORDER [ORDER_N] = '{EV_SINGLE, EV_LONG, EV_REPEAT};

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_GAP    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT        = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [LEVEL_W-1:0] key_levels;
      logic [INDEX_W-1:0] key_index;
      logic [KIND_W-1:0]  event_kind;
   } req_word_type;

   typedef struct packed {
      logic              event_present;
      logic [CODE_W-1:0] status_code;
   } rsp_word_type;

   typedef struct packed {
      logic [TIME_W-1:0] long_press_time;
      logic [TIME_W-1:0] double_gap_time;
      logic [TIME_W-1:0] repeat_time;
   } times_type;

   typedef struct packed {
      logic              tick;
      logic              sample;
      logic              pressed;
      logic [FLAG_W-1:0] clear;
   } lane_ctrl_type;

endpackage

`default_nettype wire

>>> src/kced_lane.sv
// One key's lane: countdown, click phase machine, level and event flags.
`default_nettype none

module kced_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kced_pkg::times_type     times,
   input  wire kced_pkg::lane_ctrl_type ctrl,
   output logic [kced_pkg::FLAG_W-1:0] flags
);
   import kced_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_PRESSED   = 3'd1,
      PH_GAP       = 3'd2,
      PH_SECOND    = 3'd3,
      PH_REPEATING = 3'd4
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [TIME_W-1:0] count_ff, count_in, count_dec;
   logic              level_ff, level_in;
   logic [FLAG_W-1:0] flags_ff, flags_in;

   assign count_dec = (count_ff != '0) ? count_ff - TIME_W'(1) : count_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      level_in = level_ff;
      flags_in = flags_ff & ~ctrl.clear;
      if (ctrl.tick) begin
         count_in = count_dec;
         if (ctrl.sample) begin
            level_in = ctrl.pressed;
            flags_in[EV_HOLD] = ctrl.pressed;
            if (ctrl.pressed && !level_ff) begin
               flags_in[EV_DOWN] = 1'b1;
            end
            if (!ctrl.pressed && level_ff) begin
               flags_in[EV_UP] = 1'b1;
            end
            unique case (phase_ff)
               PH_IDLE: begin
                  if (ctrl.pressed) begin
                     count_in = times.long_press_time;
                     phase_in = PH_PRESSED;
                  end
               end
               PH_PRESSED: begin
                  if (!ctrl.pressed) begin
                     count_in = times.double_gap_time;
                     phase_in = PH_GAP;
                  end else if (count_dec == '0) begin
                     count_in = times.repeat_time;
                     flags_in[EV_LONG] = 1'b1;
                     phase_in = PH_REPEATING;
                  end
               end
               PH_GAP: begin
                  if (ctrl.pressed) begin
                     flags_in[EV_DOUBLE] = 1'b1;
                     phase_in = PH_SECOND;
                  end else if (count_dec == '0) begin
                     flags_in[EV_SINGLE] = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               PH_SECOND: begin
                  if (!ctrl.pressed) begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_REPEATING: begin
                  if (!ctrl.pressed) begin
                     phase_in = PH_IDLE;
                  end else if (count_dec == '0) begin
                     count_in = times.repeat_time;
                     flags_in[EV_REPEAT] = 1'b1;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         level_ff <= 1'b0;
         flags_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         level_ff <= level_in;
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

`default_nettype wire

>>> src/kced_merge.sv
// Merging stage: flag check for one key and priority status scan over all keys.
`default_nettype none

module kced_merge (
   input  wire kced_pkg::req_word_type                      req,
   input  wire logic [kced_pkg::KEYS-1:0][kced_pkg::FLAG_W-1:0] flags,
   output kced_pkg::rsp_word_type                            rsp,
   output logic [kced_pkg::KEYS-1:0][kced_pkg::FLAG_W-1:0]   clear
);
   import kced_pkg::*;

   logic [FLAG_W-1:0] kind_mask;
   logic              found;

   always_comb begin
      for (int j = 0; j < FLAG_W; j++) begin
         kind_mask[j] = (req.event_kind == KIND_W'(j));
      end
   end

   always_comb begin
      rsp   = '0;
      clear = '0;
      found = 1'b0;
      case (req.command)
         CMD_CHECK: begin
            for (int k = 0; k < KEYS; k++) begin
               if (int'(req.key_index) == k) begin
                  if ((flags[k] & kind_mask) != '0) begin
                     rsp.event_present = 1'b1;
                  end
                  clear[k] = flags[k] & kind_mask;
                  clear[k][EV_HOLD] = 1'b0;
               end
            end
         end
         CMD_STATUS: begin
            for (int k = 0; k < KEYS; k++) begin
               for (int j = 0; j < ORDER_N; j++) begin
                  if (!found && flags[k][STATUS_ORDER[j]]) begin
                     found = 1'b1;
                     rsp.status_code = CODE_W'(1 + k * ORDER_N + j);
                     clear[k][STATUS_ORDER[j]] = 1'b1;
                  end
               end
            end
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/key_click_event_detector.sv
// Top level of the key click event detector: registers, lanes, merge and output skid stage.
// A result word is registered in the output register, or in the skid stage while the output register is held.
// Throughput: one request word per cycle; the request side stalls only while the output
// register and the one-word skid stage behind it both hold words that wait to be taken.
// Reset (synchronous, active high) clears all flags, phases, countdowns and the sample
// divider, and restores the configuration registers to their default values.
`default_nettype none

module key_click_event_detector (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire kced_pkg::req_word_type            req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output kced_pkg::rsp_word_type                 rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [kced_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [kced_pkg::CSR_DAT_W-1:0]    csr_data
);
   import kced_pkg::*;

   logic [PERIOD_W-1:0] sample_period_ff;
   logic [TIME_W-1:0]   long_press_ff, double_gap_ff, repeat_ff;
   logic [PERIOD_W-1:0] divider_ff, divider_in, divider_next;

   logic                accept, tick, sample, out_free;
   logic [KEYS-1:0]     level_bits;
   times_type           times;
   lane_ctrl_type [KEYS-1:0]         lane_ctrl;
   logic [KEYS-1:0][FLAG_W-1:0]      lane_flags, lane_clear;
   rsp_word_type        result;

   logic                rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   rsp_word_type        rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff <= PERIOD_W'(20);
         long_press_ff    <= TIME_W'(1000);
         double_gap_ff    <= TIME_W'(200);
         repeat_ff        <= TIME_W'(100);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_data[PERIOD_W-1:0];
            CSR_LONG_PRESS:    long_press_ff    <= csr_data[TIME_W-1:0];
            CSR_DOUBLE_GAP:    double_gap_ff    <= csr_data[TIME_W-1:0];
            CSR_REPEAT:        repeat_ff        <= csr_data[TIME_W-1:0];
            default:           sample_period_ff <= sample_period_ff;
         endcase
      end
   end

   assign times.long_press_time = long_press_ff;
   assign times.double_gap_time = double_gap_ff;
   assign times.repeat_time     = repeat_ff;

   assign req_stall    = skid_valid_ff;
   assign accept       = req_valid && !req_stall;
   assign tick         = accept && (req_data.command == CMD_TICK);
   assign divider_next = divider_ff + PERIOD_W'(1);
   assign sample       = tick && (divider_next >= sample_period_ff);

   always_comb begin
      divider_in = divider_ff;
      if (sample) begin
         divider_in = '0;
      end else if (tick) begin
         divider_in = divider_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= '0;
      end else begin
         divider_ff <= divider_in;
      end
   end

   kced_merge u_merge (
      .req   (req_data),
      .flags (lane_flags),
      .rsp   (result),
      .clear (lane_clear)
   );

   for (genvar k = 0; k < KEYS; k++) begin : g_lane
      if (k < LEVEL_W) begin : g_level
         assign level_bits[k] = req_data.key_levels[k];
      end else begin : g_none
         assign level_bits[k] = 1'b0;
      end

      assign lane_ctrl[k].tick    = tick;
      assign lane_ctrl[k].sample  = sample;
      assign lane_ctrl[k].pressed = level_bits[k];
      assign lane_ctrl[k].clear   = accept ? lane_clear[k] : '0;

      kced_lane u_lane (
         .clock (clock),
         .reset (reset),
         .times (times),
         .ctrl  (lane_ctrl[k]),
         .flags (lane_flags[k])
      );
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The skid stage only fills behind a word that is already waiting.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held with an empty output register");

   // An accepted request always leaves a word waiting on the response side.
   assert property (@(posedge clock) disable iff (reset) accept |=> rsp_valid_ff)
      else $error("accepted request produced no response word");

   // A check or status request clears at most one flag over all keys.
   assert property (@(posedge clock) disable iff (reset) $onehot0(lane_clear))
      else $error("more than one event flag cleared by one request");

   // A sample always leaves the divider at zero.
   assert property (@(posedge clock) disable iff (reset) sample |=> (divider_ff == '0))
      else $error("sample divider not restarted after a sample");

endmodule

`default_nettype wire
